>>> rtl/core/pn_pkg.sv
// shared types and constants of the peak normalizer
package pn_pkg;

  localparam int WINDOW_DEPTH = 1024;
  localparam int SAMPLE_WIDTH = 16;
  localparam int LEVEL_W      = 15;
  localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int PEAK_W       = SAMPLE_WIDTH;
  localparam int DVD_W        = SAMPLE_WIDTH + LEVEL_W + 1;
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LEVEL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PEAK     = 1'd1;

  localparam logic [LEVEL_W-1:0] TARGET_LEVEL_RST = 15'd29491;
  localparam logic [LEVEL_W-1:0] MIN_PEAK_RST     = 15'd369;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_READ = 1'b1
  } req_e;

  typedef struct packed {
    req_e                            kind;
    logic signed [SAMPLE_WIDTH-1:0]  sample;
    logic                            last;
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [PEAK_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> rtl/core/peak_normalizer.sv
// top level of the peak normalizer
// Loads a window of up to 1024 signed samples (req_type 0) until a beat with
// last_sample set, tracking the highest and lowest value, then reads them back
// (req_type 1) scaled to sample*target_level/peak, or raw if the peak is zero or
// below min_peak. Every read returns one beat, loads return none. Request beats go
// into a two-entry queue, so up to two beats are taken in while the back end
// is busy or a result waits. In the back end a load is handled in idle; a read
// with no window goes straight to done; a read of a rejected window passes
// through memory and done; a read of an accepted window also passes through
// multiply and divide, where the divider produces one quotient bit per cycle
// over a 32-bit product. Configuration writes take effect at once.
module peak_normalizer import pn_pkg::*; (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [LEVEL_W-1:0]             cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           req_type_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_value_i,
  input  logic                           last_sample_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] scaled_sample_o,
  output logic                           accepted_o,
  output logic                           end_of_window_o
);

  logic     cmd_valid;
  cmd_t     cmd;
  logic     cmd_pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // request queue
  pn_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .sample_value_i (sample_value_i),
    .last_sample_i  (last_sample_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  // divider
  pn_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // window store and scaling
  pn_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_pop_o       (cmd_pop),
    .div_req_o       (div_req),
    .div_rsp_i       (div_rsp),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .scaled_sample_o (scaled_sample_o),
    .accepted_o      (accepted_o),
    .end_of_window_o (end_of_window_o)
  );

endmodule

>>> rtl/core/pn_front.sv
// front end: accepts request beats, classifies them and queues them
module pn_front import pn_pkg::*; (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           req_type_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_value_i,
  input  logic                           last_sample_i,
  output logic                           cmd_valid_o,
  output cmd_t                           cmd_o,
  input  logic                           cmd_pop_i
);

  cmd_t              queue_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;
  cmd_t              cmd_in;

  // decode the request beat
  always_comb begin
    cmd_in.kind   = req_e'(req_type_i);
    cmd_in.sample = sample_value_i;
    cmd_in.last   = last_sample_i;
  end

  assign in_ready_o  = cnt_q != QCNT_W'(QDEPTH);
  assign cmd_valid_o = cnt_q != '0;
  assign cmd_o       = queue_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

>>> rtl/core/pn_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module pn_div import pn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int STEP_W = $clog2(DVD_W);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [DVD_W-1:0]  dvd_q;
  logic [PEAK_W-1:0] rem_q;
  logic [PEAK_W-1:0] dsr_q;
  logic [PEAK_W:0]   shifted;
  logic [PEAK_W:0]   diff;
  logic              fits;

  // trial subtraction of one step
  assign shifted = {rem_q, dvd_q[DVD_W-1]};
  assign diff    = shifted - {1'b0, dsr_q};
  assign fits    = shifted >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(DVD_W - 1);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: dividend register fills with quotient bits
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], fits};
      rem_q <= fits ? diff[PEAK_W-1:0] : shifted[PEAK_W-1:0];
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

>>> rtl/core/pn_back.sv
// back end: window store, peak tracking, scaling and result register
module pn_back import pn_pkg::*; (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [LEVEL_W-1:0]             cfg_wdata_i,
  input  logic                           cmd_valid_i,
  input  cmd_t                           cmd_i,
  output logic                           cmd_pop_o,
  output div_req_t                       div_req_o,
  input  div_rsp_t                       div_rsp_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] scaled_sample_o,
  output logic                           accepted_o,
  output logic                           end_of_window_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEM,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  state_e                          state_q;
  logic [LEVEL_W-1:0]              target_q;
  logic [LEVEL_W-1:0]              min_peak_q;
  logic [CNT_W-1:0]                wc_q;
  logic [ADDR_W-1:0]               rd_idx_q;
  logic signed [SAMPLE_WIDTH-1:0]  hi_q, lo_q;
  logic                            win_ready_q;
  logic                            win_acc_q;
  logic [PEAK_W-1:0]               peak_q;
  logic signed [SAMPLE_WIDTH-1:0]  store_q [WINDOW_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0]  rd_data_q;
  logic signed [DVD_W-1:0]         prod_q;
  logic                            neg_q;
  logic                            res_acc_q, res_eow_q;
  logic signed [SAMPLE_WIDTH-1:0]  res_q;
  logic                            out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0]  out_sample_q;
  logic                            out_acc_q, out_eow_q;

  logic                            pop_load, pop_read, read_live;
  logic [CNT_W-1:0]                base_cnt;
  logic signed [SAMPLE_WIDTH-1:0]  base_hi, base_lo, hi_new, lo_new;
  logic                            store_ok;
  logic [PEAK_W-1:0]               mag_hi, mag_lo, peak_new;
  logic [ADDR_W-1:0]               rd_addr;
  logic                            rd_last;
  logic [DVD_W-1:0]                mag_prod;
  logic [DVD_W-1:0]                quo;
  logic signed [SAMPLE_WIDTH-1:0]  sat_res;
  logic                            out_free;

  assign out_free  = !out_valid_q || out_ready_i;
  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;
  assign pop_load  = cmd_pop_o && (cmd_i.kind == REQ_LOAD);
  assign pop_read  = cmd_pop_o && (cmd_i.kind == REQ_READ);
  assign read_live = win_ready_q && (wc_q != '0);

  // load path: a load after a closed window starts over
  always_comb begin
    base_cnt = win_ready_q ? '0 : wc_q;
    base_hi  = win_ready_q ? '0 : hi_q;
    base_lo  = win_ready_q ? '0 : lo_q;
    store_ok = base_cnt < CNT_W'(WINDOW_DEPTH);
    hi_new   = (store_ok && (cmd_i.sample > base_hi)) ? cmd_i.sample : base_hi;
    lo_new   = (store_ok && (cmd_i.sample < base_lo)) ? cmd_i.sample : base_lo;
    mag_hi   = PEAK_W'(hi_new);
    mag_lo   = PEAK_W'(-lo_new);
    peak_new = (mag_hi > mag_lo) ? mag_hi : mag_lo;
  end

  // read path address and end of window
  always_comb begin
    rd_addr = (CNT_W'(rd_idx_q) >= wc_q) ? '0 : rd_idx_q;
    rd_last = (CNT_W'(rd_addr) + 1'b1) >= wc_q;
  end

  // magnitude, divider request and saturation
  assign mag_prod = neg_q ? DVD_W'(-prod_q) : DVD_W'(prod_q);
  assign quo      = div_rsp_i.quotient;

  always_comb begin
    if (neg_q) begin
      sat_res = (quo > DVD_W'(2 ** (SAMPLE_WIDTH - 1))) ? SMIN
                : SAMPLE_WIDTH'(-quo);
    end else begin
      sat_res = (quo > DVD_W'(SMAX)) ? SMAX : SAMPLE_WIDTH'(quo);
    end
  end

  always_comb begin
    div_req_o.start    = state_q == ST_MUL;
    div_req_o.dividend = mag_prod;
    div_req_o.divisor  = peak_q;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= TARGET_LEVEL_RST;
      min_peak_q <= MIN_PEAK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TARGET_LEVEL: target_q   <= cfg_wdata_i;
        CFG_MIN_PEAK:     min_peak_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // window store, one write or one read per cycle
  always_ff @(posedge clk_i) begin
    if (pop_load && store_ok) begin
      store_q[base_cnt[ADDR_W-1:0]] <= cmd_i.sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_read) begin
      rd_data_q <= store_q[rd_addr];
    end
  end

  // sequencer, window state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      wc_q         <= '0;
      rd_idx_q     <= '0;
      hi_q         <= '0;
      lo_q         <= '0;
      win_ready_q  <= 1'b0;
      win_acc_q    <= 1'b0;
      peak_q       <= '0;
      out_valid_q  <= 1'b0;
      prod_q       <= '0;
      neg_q        <= 1'b0;
      res_q        <= '0;
      res_acc_q    <= 1'b0;
      res_eow_q    <= 1'b0;
      out_sample_q <= '0;
      out_acc_q    <= 1'b0;
      out_eow_q    <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_load) begin
            wc_q <= store_ok ? base_cnt + 1'b1 : base_cnt;
            hi_q <= hi_new;
            lo_q <= lo_new;
            if (cmd_i.last) begin
              peak_q      <= peak_new;
              win_acc_q   <= (peak_new != '0) && (peak_new >= PEAK_W'(min_peak_q));
              win_ready_q <= 1'b1;
              rd_idx_q    <= '0;
            end else if (win_ready_q) begin
              rd_idx_q    <= '0;
              win_ready_q <= 1'b0;
              win_acc_q   <= 1'b0;
              peak_q      <= '0;
            end
          end else if (pop_read) begin
            if (read_live) begin
              res_acc_q <= win_acc_q;
              res_eow_q <= rd_last;
              rd_idx_q  <= rd_last ? '0 : rd_addr + 1'b1;
              state_q   <= ST_MEM;
            end else begin
              res_q     <= '0;
              res_acc_q <= 1'b0;
              res_eow_q <= 1'b0;
              state_q   <= ST_DONE;
            end
          end
        end
        ST_MEM: begin
          if (res_acc_q) begin
            prod_q  <= DVD_W'(rd_data_q * $signed({1'b0, target_q}));
            neg_q   <= rd_data_q[SAMPLE_WIDTH-1];
            state_q <= ST_MUL;
          end else begin
            res_q   <= rd_data_q;
            state_q <= ST_DONE;
          end
        end
        ST_MUL: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_rsp_i.done) begin
            res_q   <= sat_res;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_sample_q <= res_q;
            out_acc_q    <= res_acc_q;
            out_eow_q    <= res_eow_q;
            state_q      <= ST_IDLE;
          end else if (out_valid_q && out_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign scaled_sample_o = out_sample_q;
  assign accepted_o      = out_acc_q;
  assign end_of_window_o = out_eow_q;

endmodule
